### src/rbs_pkg.sv
// Shared types and constants for the reset button supervisor.
`default_nettype none

package rbs_pkg;

  localparam int unsigned CountWidth = 10;
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned DataWidth  = 32;

  // Debouncer states; bit 1 set means the debounced switch is pressed.
  localparam logic [1:0] ST_RELEASED  = 2'd0;
  localparam logic [1:0] ST_PRESSING  = 2'd1;
  localparam logic [1:0] ST_PRESSED   = 2'd2;
  localparam logic [1:0] ST_RELEASING = 2'd3;

  // Register byte addresses.
  localparam logic [AddrWidth-1:0] ADDR_DEBOUNCE_TICKS  = 3'd0;
  localparam logic [AddrWidth-1:0] ADDR_RESET_MIN_TICKS = 3'd4;

  localparam logic [CountWidth-1:0] DEBOUNCE_TICKS_RST  = 10'd25;
  localparam logic [TimerWidth-1:0] RESET_MIN_TICKS_RST = 16'd250;

  typedef struct packed {
    logic reset_assert;
    logic halt_led;
  } result_t;

endpackage

`default_nettype wire

### src/reset_button_supervisor.sv
// Top level of the reset button supervisor: debouncer, reset timer and output skid.
`default_nettype none

// Reset button supervisor. Each input word is one sampling tick carrying the
// button level (switch_pressed, 1 = pressed) and the CPU halt line (halt_line,
// 0 = halted); each tick gives exactly one output word. On a tick the minimum
// reset timer first counts down if nonzero, then a four-state debouncer
// (released, pressing, pressed, releasing) follows the button: a change must
// hold for debounce_ticks + 1 consecutive ticks (a value of 0 needs 1025). When the
// debounced switch becomes pressed the timer reloads from reset_min_ticks.
// reset_assert is high while the switch is held or the timer is nonzero, so it
// is also high for the first 249 ticks after reset. halt_led is the inverse
// of halt_line. Throughput is one word per clock while out_stall is low; the
// tick logic (a counter increment and compare, a timer decrement) feeds the
// state registers, and an output register with a one-word skid stage takes
// one input word while an output word waits. out_valid comes from a register.
// Registers (APB, 32-bit data): 0x0 debounce_ticks (10 bits, reset 25),
// 0x4 reset_min_ticks (16 bits, reset 250). Writing reset_min_ticks does not
// reload a running timer; it applies at the next press.
module reset_button_supervisor (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbs_pkg::AddrWidth-1:0] paddr,
  input  wire logic [rbs_pkg::DataWidth-1:0] pwdata,
  output logic      [rbs_pkg::DataWidth-1:0] prdata,
  output logic                               pready,
  // input words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          switch_pressed,
  input  wire logic                          halt_line,
  // output words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               reset_assert,
  output logic                               halt_led
);

  // Configuration registers
  logic [rbs_pkg::CountWidth-1:0] debounce_ticks;
  logic [rbs_pkg::TimerWidth-1:0] reset_min_ticks;

  // Supervisor state
  logic [1:0]                     debounce_state, debounce_state_next;
  logic [rbs_pkg::CountWidth-1:0] debounce_count, debounce_count_next;
  logic                           held_flag, held_flag_next;
  logic [rbs_pkg::TimerWidth-1:0] min_reset_count, min_reset_count_next;

  // Output register and skid stage
  rbs_pkg::result_t result_new;
  rbs_pkg::result_t out_word;
  rbs_pkg::result_t skid_word;
  logic             skid_valid;

  logic                           cfg_write;
  logic                           in_accept;
  logic                           out_take;
  logic [rbs_pkg::CountWidth-1:0] count_inc;
  logic                           count_hit;
  logic [rbs_pkg::TimerWidth-1:0] timer_dec;

  // ---------------------------------------------------------------------
  // APB register file: zero wait states, reads are a plain mux.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks  <= rbs_pkg::DEBOUNCE_TICKS_RST;
      reset_min_ticks <= rbs_pkg::RESET_MIN_TICKS_RST;
    end else if (cfg_write) begin
      case (paddr)
        rbs_pkg::ADDR_DEBOUNCE_TICKS:  debounce_ticks  <= pwdata[rbs_pkg::CountWidth-1:0];
        rbs_pkg::ADDR_RESET_MIN_TICKS: reset_min_ticks <= pwdata[rbs_pkg::TimerWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      rbs_pkg::ADDR_DEBOUNCE_TICKS:
        prdata = {{(rbs_pkg::DataWidth-rbs_pkg::CountWidth){1'b0}}, debounce_ticks};
      rbs_pkg::ADDR_RESET_MIN_TICKS:
        prdata = {{(rbs_pkg::DataWidth-rbs_pkg::TimerWidth){1'b0}}, reset_min_ticks};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: the skid stage absorbs one word while the output is stalled,
  // so the input only stalls once both slots are full.
  // ---------------------------------------------------------------------
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // ---------------------------------------------------------------------
  // Tick logic
  // ---------------------------------------------------------------------
  assign count_inc = debounce_count + 1'b1;   // wraps at 1024
  assign count_hit = (count_inc == debounce_ticks);
  assign timer_dec = (min_reset_count != '0) ? min_reset_count - 1'b1 : min_reset_count;

  always_comb begin
    debounce_state_next  = debounce_state;
    debounce_count_next  = debounce_count;
    held_flag_next       = held_flag;
    min_reset_count_next = timer_dec;

    case (debounce_state)
      rbs_pkg::ST_RELEASED: begin
        if (switch_pressed) begin
          debounce_count_next = '0;
          debounce_state_next = rbs_pkg::ST_PRESSING;
        end
      end
      rbs_pkg::ST_PRESSING: begin
        if (!switch_pressed) begin
          debounce_state_next = rbs_pkg::ST_RELEASED;
        end else begin
          debounce_count_next = count_inc;
          if (count_hit) debounce_state_next = rbs_pkg::ST_PRESSED;
        end
      end
      rbs_pkg::ST_PRESSED: begin
        if (!switch_pressed) begin
          debounce_count_next = '0;
          debounce_state_next = rbs_pkg::ST_RELEASING;
        end
      end
      rbs_pkg::ST_RELEASING: begin
        if (switch_pressed) begin
          debounce_state_next = rbs_pkg::ST_PRESSED;
        end else begin
          debounce_count_next = count_inc;
          if (count_hit) debounce_state_next = rbs_pkg::ST_RELEASED;
        end
      end
      default: ;
    endcase

    // Bit 1 of the state: debounced switch is pressed (pressed or releasing).
    if (!held_flag) begin
      if (debounce_state_next[1]) begin
        min_reset_count_next = reset_min_ticks;
        held_flag_next       = 1'b1;
      end
    end else if (!debounce_state_next[1]) begin
      held_flag_next = 1'b0;
    end

    result_new.reset_assert = held_flag_next || (min_reset_count_next != '0);
    result_new.halt_led     = !halt_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_state  <= rbs_pkg::ST_RELEASED;
      debounce_count  <= '0;
      held_flag       <= 1'b0;
      min_reset_count <= rbs_pkg::RESET_MIN_TICKS_RST;
    end else if (in_accept) begin
      debounce_state  <= debounce_state_next;
      debounce_count  <= debounce_count_next;
      held_flag       <= held_flag_next;
      min_reset_count <= min_reset_count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_accept) begin
        out_word <= result_new;
      end
    end else if (in_accept) begin
      skid_word <= result_new;
    end
  end

  assign reset_assert = out_word.reset_assert;
  assign halt_led     = out_word.halt_led;

endmodule

`default_nettype wire
